### src/bhte_pkg.sv
// Package for the bucketed hash table engine: sizes, command and status codes,
// and the transfer payload types. No dependencies.
package bhte_pkg;

  localparam int unsigned SlotsPerCell = 2;
  localparam int unsigned MaxCells     = 256;
  localparam int unsigned KeyBits      = 32;
  localparam int unsigned DataBits     = 32;
  localparam int unsigned CellBits     = $clog2(MaxCells);
  localparam int unsigned BaseBits     = 9;
  localparam int unsigned ShiftBits    = 4;
  localparam int unsigned EntryBits    = KeyBits + DataBits;
  localparam int unsigned RowBits      = SlotsPerCell * EntryBits;
  localparam logic [8:0]  BaseReset    = 9'd16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_FULL       = 2'd2,
    ST_BAD_BUCKET = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e          cmd;
    logic [31:0]   key;
    logic [7:0]    bucket;
    logic [31:0]   value;
    logic [7:0]    at_cell;
    logic          at_slot;
  } req_t;

  typedef struct packed {
    status_e       status;
    logic [31:0]   found_data;
    logic [31:0]   found_key;
    logic [7:0]    found_cell;
    logic          found_slot;
    logic          grew;
  } rsp_t;

  // Clamp a written base cell count into 1..MaxCells.
  function automatic logic [8:0] clamp_base(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (10'(v) > 10'(MaxCells)) begin
      r = 9'(MaxCells);
    end
    return r;
  endfunction

endpackage

### src/bhte_req_if.sv
// Request channel of the hash table engine: valid/ready plus request payload.
// Depends on bhte_pkg.
interface bhte_req_if;
  logic            valid;
  logic            ready;
  bhte_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/bhte_rsp_if.sv
// Response channel of the hash table engine: valid/ready plus result payload.
// Depends on bhte_pkg.
interface bhte_rsp_if;
  logic            valid;
  logic            ready;
  bhte_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/bucketed_hash_table_engine.sv
// Top level of the bucketed hash table engine.
// Depends on bhte_pkg, bhte_req_if and bhte_rsp_if.
//
// Key/data table of 256 cells with two slots each, held in one row-wide
// memory (one row per cell, holding both slots and their valid bits; one read
// and one write port, registered read). After reset and after every
// base_cells write a clearing pass zeroes the rows, one per cycle, and the
// block is not ready until every row is cleared. The block takes one request
// at a time: req.ready is high only while idle. A result waits in an output
// register, so the next request may be taken while it is pending; a finished
// request holds in S_FIN while that register is full and rsp.ready is low.
// Bad-bucket requests and out-of-range reads go straight to S_FIN; other
// reads pass through S_RDAT; insert, find and remove scan the bucket's
// d = cells_in_use/base_cells cells at one cell per cycle in S_SCAN. An
// insert that finds no slot doubles the table in place, or returns ST_FULL
// if that would exceed 256 cells. Doubling walks down from the top cell:
// S_DBLO clears the odd cell and S_DBLE copies the even one, then S_PUT
// places the entry. The scan and copy loop over the single memory sets the
// rate. cells_in_use is always base_cells shifted left by the doubling count,
// so no divider is needed. A base_cells write must only happen while idle.
module bucketed_hash_table_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [8:0]          cfg_wdata_i,
  bhte_req_if.sink            req_i,
  bhte_rsp_if.source          rsp_o
);

  localparam int unsigned CB = bhte_pkg::CellBits;
  localparam int unsigned EB = bhte_pkg::EntryBits;
  localparam int unsigned DB = bhte_pkg::DataBits;
  localparam int unsigned RB = bhte_pkg::RowBits;
  localparam int unsigned VB = bhte_pkg::SlotsPerCell;

  typedef enum logic [2:0] {
    S_IDLE, S_CLR, S_SCAN, S_DBLO, S_DBLE, S_PUT, S_RDAT, S_FIN
  } state_e;

  // Row: {slot valid bits, slot 1 entry, slot 0 entry}
  typedef logic [RB+VB-1:0] row_t;

  // Row memory
  row_t      mem [bhte_pkg::MaxCells];
  row_t      rdata_q;
  logic          mem_we;
  logic [CB-1:0] mem_waddr, mem_raddr;
  row_t          mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Control and working registers
  state_e                           state_q, state_d;
  logic [8:0]                       base_q;
  logic [bhte_pkg::ShiftBits-1:0]   shift_q, shift_d;
  bhte_pkg::req_t                   req_q, req_d;
  logic [CB-1:0]                    cell_q, cell_d;
  logic [CB-1:0]                    first_q, first_d;
  logic [8:0]                       rem_q, rem_d;
  bhte_pkg::rsp_t                   res_q, res_d;
  bhte_pkg::rsp_t                   out_q, out_d;
  logic                             ovalid_q, ovalid_d;

  logic [9:0]    cells;
  logic [1:0]    vcur;
  logic [1:0]    vnew;
  logic [EB-1:0] ent0, ent1;
  logic [31:0]   key0, key1;
  logic [EB-1:0] new_ent;

  assign cells   = 10'(base_q) << shift_q;
  assign vcur    = rdata_q[RB +: VB];
  assign ent0    = rdata_q[0 +: EB];
  assign ent1    = rdata_q[EB +: EB];
  assign key0    = ent0[EB-1:DB];
  assign key1    = ent1[EB-1:DB];
  assign new_ent = {req_q.key, req_q.value};

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = ovalid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    state_d   = state_q;
    shift_d   = shift_q;
    req_d     = req_q;
    cell_d    = cell_q;
    first_d   = first_q;
    rem_d     = rem_q;
    res_d     = res_q;
    out_d     = out_q;
    ovalid_d  = ovalid_q & ~rsp_o.ready;
    mem_we    = 1'b0;
    mem_waddr = cell_q;
    mem_wdata = rdata_q;
    mem_raddr = cell_q;
    vnew      = vcur;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d = req_i.data;
          res_d = '0;
          if (req_i.data.cmd == bhte_pkg::CMD_READ) begin
            cell_d    = req_i.data.at_cell;
            mem_raddr = req_i.data.at_cell;
            if (10'(req_i.data.at_cell) >= cells) begin
              res_d.status = bhte_pkg::ST_NOT_FOUND;
              state_d      = S_FIN;
            end else begin
              state_d = S_RDAT;
            end
          end else if (9'(req_i.data.bucket) >= base_q) begin
            res_d.status = bhte_pkg::ST_BAD_BUCKET;
            state_d      = S_FIN;
          end else begin
            first_d   = CB'(9'(req_i.data.bucket) << shift_q);
            cell_d    = first_d;
            mem_raddr = first_d;
            rem_d     = 9'(1) << shift_q;
            state_d   = S_SCAN;
          end
        end
      end

      // Zero every row, one per cycle.
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_q;
        mem_wdata = '0;
        if (cell_q == '1) begin
          state_d = S_IDLE;
        end else begin
          cell_d = cell_q + CB'(1);
        end
      end

      // One cell per cycle: row data of cell_q is in rdata_q.
      S_SCAN: begin
        if (req_q.cmd == bhte_pkg::CMD_INSERT) begin
          if (!vcur[0] || key0 == req_q.key) begin
            mem_we    = 1'b1;
            mem_wdata = {vcur[1], 1'b1, ent1, new_ent};
            res_d.found_cell = cell_q;
            res_d.found_slot = 1'b0;
            state_d   = S_FIN;
          end else if (!vcur[1] || key1 == req_q.key) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, vcur[0], new_ent, ent0};
            res_d.found_cell = cell_q;
            res_d.found_slot = 1'b1;
            state_d   = S_FIN;
          end else if (rem_q == 9'd1) begin
            if ({cells, 1'b0} > 11'(bhte_pkg::MaxCells)) begin
              res_d.status = bhte_pkg::ST_FULL;
              state_d      = S_FIN;
            end else begin
              // start doubling from the top cell downward
              cell_d    = CB'(cells - 10'd1);
              mem_raddr = cell_d;
              state_d   = S_DBLO;
            end
          end else begin
            rem_d     = rem_q - 9'd1;
            cell_d    = cell_q + CB'(1);
            mem_raddr = cell_d;
          end
        end else begin
          if ((vcur[0] && key0 == req_q.key) || (vcur[1] && key1 == req_q.key)) begin
            if (vcur[0] && key0 == req_q.key) begin
              res_d.found_slot = 1'b0;
              res_d.found_data = ent0[DB-1:0];
              vnew             = {vcur[1], 1'b0};
            end else begin
              res_d.found_slot = 1'b1;
              res_d.found_data = ent1[DB-1:0];
              vnew             = {1'b0, vcur[0]};
            end
            res_d.found_cell = cell_q;
            mem_we           = (req_q.cmd == bhte_pkg::CMD_REMOVE);
            mem_wdata        = {vnew, rdata_q[RB-1:0]};
            state_d          = S_FIN;
          end else if (rem_q == 9'd1) begin
            res_d.status     = bhte_pkg::ST_NOT_FOUND;
            res_d.found_cell = '1;
            res_d.found_slot = 1'b1;
            state_d          = S_FIN;
          end else begin
            rem_d     = rem_q - 9'd1;
            cell_d    = cell_q + CB'(1);
            mem_raddr = cell_d;
          end
        end
      end

      // Doubling, odd half: clear cell 2i+1 while row i is read again.
      S_DBLO: begin
        mem_we    = 1'b1;
        mem_waddr = {cell_q[CB-2:0], 1'b1};
        mem_wdata = '0;
        state_d   = S_DBLE;
      end

      // Doubling, even half: copy row i to 2i; descending order keeps
      // sources intact.
      S_DBLE: begin
        mem_we    = 1'b1;
        mem_waddr = {cell_q[CB-2:0], 1'b0};
        mem_wdata = rdata_q;
        if (cell_q == '0) begin
          shift_d = shift_q + bhte_pkg::ShiftBits'(1);
          state_d = S_PUT;
        end else begin
          cell_d    = cell_q - CB'(1);
          mem_raddr = cell_d;
          state_d   = S_DBLO;
        end
      end

      // New entry in slot 0 of cell 2*first+1 (slot 1 stays invalid).
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = {first_q[CB-2:0], 1'b1};
        mem_wdata = {2'b01, {EB{1'b0}}, new_ent};
        res_d.found_cell = {first_q[CB-2:0], 1'b1};
        res_d.found_slot = 1'b0;
        res_d.grew       = 1'b1;
        state_d   = S_FIN;
      end

      S_RDAT: begin
        if (vcur[req_q.at_slot]) begin
          res_d.found_cell = cell_q;
          res_d.found_slot = req_q.at_slot;
          if (req_q.at_slot) begin
            res_d.found_key  = key1;
            res_d.found_data = ent1[DB-1:0];
          end else begin
            res_d.found_key  = key0;
            res_d.found_data = ent0[DB-1:0];
          end
        end else begin
          res_d.status = bhte_pkg::ST_NOT_FOUND;
        end
        state_d = S_FIN;
      end

      S_FIN: begin
        if (!ovalid_q || rsp_o.ready) begin
          out_d    = res_q;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      base_q   <= bhte_pkg::BaseReset;
      shift_q  <= '0;
      cell_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        // fresh table
        state_q <= S_CLR;
        base_q  <= bhte_pkg::clamp_base(cfg_wdata_i);
        shift_q <= '0;
        cell_q  <= '0;
      end else begin
        state_q <= state_d;
        shift_q <= shift_d;
        cell_q  <= cell_d;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    first_q <= first_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule
